### hw/rtl/text_console_char_writer_assert.svh
// ---------------------------------------------------------------------------
// text console char writer: assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define TCW_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw port check failed");

// next-cycle implication, off while reset is high
`define TCW_ASSERT_HOLD(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw port check failed");

// next-cycle implication, active through reset
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tcw port check failed");

`endif

### hw/rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// types and constants shared by the text console writer modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // widest row and column indexes over the supported screen sizes
  localparam int ROW_W = 7;
  localparam int COL_W = 8;
  localparam int CELL_W = 16;
  // wide enough for any row * columns + column address
  localparam int CALC_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL     = 16'h0720;
  localparam logic [7:0]        TEXT_ATTR      = 8'h07;
  localparam logic [CELL_W-1:0] BACKSPACE_CELL = 16'h0020;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  localparam int OP_QUEUE_DEPTH  = 4;
  localparam int RES_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SCROLL = 3'd4
  } op_kind_t;

  // one classified operation for the back end
  typedef struct packed {
    op_kind_t              kind;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [CELL_W-1:0]     data;
    logic [ROW_W-1:0]      cur_row;
    logic [COL_W-1:0]      cur_col;
  } op_t;

  // one finished result beat
  typedef struct packed {
    logic [CELL_W-1:0]     value;
    logic [ROW_W-1:0]      cur_row;
    logic [COL_W-1:0]      cur_col;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/tcw_fifo.sv
// ---------------------------------------------------------------------------
// tcw_fifo
// small register queue with push/full and pop/empty sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tcw_front.sv
// ---------------------------------------------------------------------------
// tcw_front
// owns the cursor and turns each accepted beat into one screen operation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        cmd,
  input  logic [7:0]        char_code,
  input  logic [4:0]        cell_row,
  input  logic [6:0]        cell_col,
  output tcw_pkg::op_t      op
);

  logic [tcw_pkg::ROW_W-1:0] crow;
  logic [tcw_pkg::ROW_W-1:0] crow_next;
  logic [tcw_pkg::COL_W-1:0] ccol;
  logic [tcw_pkg::COL_W-1:0] ccol_next;
  logic                      read_ok;

  assign read_ok = (int'(cell_row) < ROWS) && (int'(cell_col) < COLUMNS);

  always_comb begin
    crow_next = crow;
    ccol_next = ccol;
    op.kind   = tcw_pkg::OP_NOP;
    op.row    = crow;
    op.col    = ccol;
    op.data   = tcw_pkg::BLANK_CELL;
    unique case (cmd)
      tcw_pkg::CMD_PUT: begin
        case (char_code)
          tcw_pkg::CH_NEWLINE: begin
            ccol_next = '0;
            if (int'(crow) == ROWS - 1) begin
              // scroll: back end rotates rows starting at logical row zero
              op.kind = tcw_pkg::OP_SCROLL;
              op.row  = '0;
              op.col  = '0;
            end else begin
              crow_next = crow + 1'b1;
            end
          end
          tcw_pkg::CH_RETURN: begin
            ccol_next = '0;
          end
          tcw_pkg::CH_BACKSPACE: begin
            if (ccol != '0) begin
              ccol_next = ccol - 1'b1;
              op.kind   = tcw_pkg::OP_WRITE;
              op.col    = ccol - 1'b1;
              op.data   = tcw_pkg::BACKSPACE_CELL;
            end
          end
          default: begin
            op.kind = tcw_pkg::OP_WRITE;
            op.data = {tcw_pkg::TEXT_ATTR, char_code};
            if (int'(ccol) != COLUMNS - 1) begin
              ccol_next = ccol + 1'b1;
            end
          end
        endcase
      end
      tcw_pkg::CMD_READ: begin
        if (read_ok) begin
          op.kind = tcw_pkg::OP_READ;
          op.row  = {2'b00, cell_row};
          op.col  = {1'b0, cell_col};
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        op.kind = tcw_pkg::OP_CLEAR;
      end
      default: begin
        op.kind = tcw_pkg::OP_NOP;
      end
    endcase
    op.cur_row = crow_next;
    op.cur_col = ccol_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crow <= '0;
      ccol <= '0;
    end else if (accept) begin
      crow <= crow_next;
      ccol <= ccol_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tcw_back.sv
// ---------------------------------------------------------------------------
// tcw_back
// screen memory sequencer: writes, reads, row scroll and full clears
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  tcw_pkg::op_t      op_rdata,
  input  logic              op_empty,
  output logic              op_pop,
  output tcw_pkg::res_t     res_wdata,
  input  logic              res_full,
  output logic              res_push,
  output logic              init_busy
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int RW     = tcw_pkg::ROW_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [RW:0]   ROWS_EXT = (RW + 1)'(ROWS);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ROW,
    S_ADDR,
    S_WRITE,
    S_READ,
    S_READ_DATA,
    S_SCROLL,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t                       state;
  tcw_pkg::op_t                 op;
  logic [RW-1:0]                top;
  logic [RW-1:0]                phys;
  logic [ADDR_W-1:0]            addr;
  logic [tcw_pkg::COL_W-1:0]    col_cnt;
  logic [tcw_pkg::CELL_W-1:0]   value;
  logic [tcw_pkg::CELL_W-1:0]   rd_data;
  logic [tcw_pkg::CELL_W-1:0]   mem [CELLS];

  logic                         mem_we;
  logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
  logic [RW:0]                  row_sum;
  logic [RW:0]                  row_wrap;
  logic [tcw_pkg::CALC_W-1:0]   addr_calc;

  // logical row to physical row through the scroll offset
  assign row_sum  = {1'b0, op.row} + {1'b0, top};
  assign row_wrap = (row_sum >= ROWS_EXT) ? row_sum - ROWS_EXT : row_sum;
  assign addr_calc = tcw_pkg::CALC_W'(phys) * tcw_pkg::CALC_W'(COLUMNS)
                   + tcw_pkg::CALC_W'(op.col);

  assign op_pop    = (state == S_IDLE) && !op_empty && !res_full;
  assign res_push  = (state == S_DONE);
  assign init_busy = (state == S_INIT);
  assign res_wdata = '{value: value, cur_row: op.cur_row, cur_col: op.cur_col};

  assign mem_we = (state == S_INIT) || (state == S_CLEAR) || (state == S_SCROLL)
               || (state == S_WRITE);
  assign mem_wdata = (state == S_WRITE) ? op.data : tcw_pkg::BLANK_CELL;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      top     <= '0;
      addr    <= '0;
      col_cnt <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (op_pop) begin
            op    <= op_rdata;
            value <= '0;
            case (op_rdata.kind)
              tcw_pkg::OP_NOP: begin
                state <= S_DONE;
              end
              tcw_pkg::OP_CLEAR: begin
                addr  <= '0;
                state <= S_CLEAR;
              end
              default: begin
                state <= S_ROW;
              end
            endcase
          end
        end
        S_ROW: begin
          phys  <= row_wrap[RW-1:0];
          state <= S_ADDR;
        end
        S_ADDR: begin
          addr    <= addr_calc[ADDR_W-1:0];
          col_cnt <= '0;
          case (op.kind)
            tcw_pkg::OP_WRITE:  state <= S_WRITE;
            tcw_pkg::OP_READ:   state <= S_READ;
            tcw_pkg::OP_SCROLL: state <= S_SCROLL;
            default:            state <= S_DONE;
          endcase
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_READ: begin
          state <= S_READ_DATA;
        end
        S_READ_DATA: begin
          value <= rd_data;
          state <= S_DONE;
        end
        S_SCROLL: begin
          // blank the old top row, which becomes the new bottom row
          if (col_cnt == LAST_COL) begin
            top   <= (top == LAST_ROW) ? '0 : top + 1'b1;
            state <= S_DONE;
          end else begin
            col_cnt <= col_cnt + 1'b1;
            addr    <= addr + 1'b1;
          end
        end
        S_CLEAR: begin
          if (addr == LAST_ADDR) begin
            state <= S_DONE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/text_console_char_writer.sv
// ---------------------------------------------------------------------------
// text_console_char_writer
// text-mode console: screen cell store, cursor, put/read/clear commands
// ---------------------------------------------------------------------------
// usage
//   input channel: drive cmd, char_code, cell_row, cell_col and raise push;
//     the beat is taken on an edge where push is high and full is low
//   result channel: while empty is low the oldest result sits on cell_value,
//     cursor_row and cursor_col; raise pop to take it
//   every input beat gives exactly one result beat, in order
// operations and throughput
//   plain byte or backspace past column 0: one cell write; on-screen read:
//     one cell read; any other beat touches no cell; newline on the last row:
//     the single-port screen memory blanks one row (rows rotate, no copy)
//   clear: ROWS * COLUMNS cells, one cell written per cycle
//   a 4-entry operation queue lets several commands be taken back to back
// reset
//   the cursor goes to row 0, column 0 and the screen memory is blanked by
//   a sweep over all ROWS * COLUMNS cells; full stays high until it is done
// stalls
//   a 2-entry result queue holds finished results; the sequencer takes no
//   new operation while that queue is full, and push sees full once the
//   operation queue fills behind it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [4:0]  cell_row,
  input  logic [6:0]  cell_col,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [15:0] cell_value,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col
);

  tcw_pkg::op_t  op_new;
  tcw_pkg::op_t  op_head;
  tcw_pkg::res_t res_new;
  tcw_pkg::res_t res_head;
  logic          op_full;
  logic          op_empty;
  logic          op_pop;
  logic          res_full;
  logic          res_push;
  logic          init_busy;
  logic          accept;

  // no beats taken while the reset sweep runs
  assign full   = op_full | init_busy;
  assign accept = push & ~full;

  // front: cursor tracking and command classification
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .char_code (char_code),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .op        (op_new)
  );

  // decoupling queue between front and back
  tcw_fifo #(
    .WIDTH ($bits(tcw_pkg::op_t)),
    .DEPTH (tcw_pkg::OP_QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (op_new),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_head),
    .empty (op_empty)
  );

  // back: screen memory sequencer
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_rdata  (op_head),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .res_wdata (res_new),
    .res_full  (res_full),
    .res_push  (res_push),
    .init_busy (init_busy)
  );

  // finished results wait here for the receiver
  tcw_fifo #(
    .WIDTH ($bits(tcw_pkg::res_t)),
    .DEPTH (tcw_pkg::RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_new),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  // cursor fields are reported in the port widths
  assign cell_value = res_head.value;
  assign cursor_row = res_head.cur_row[4:0];
  assign cursor_col = res_head.cur_col[6:0];

endmodule

`default_nettype wire

### hw/rtl/tcw_port_check.sv
// ---------------------------------------------------------------------------
// tcw_port_check
// port-level checks on the text console writer, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_char_writer_assert.svh"

module tcw_port_check #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] cell_value,
  input logic [4:0]  cursor_row,
  input logic [6:0]  cursor_col
);

  // the blanking sweep after reset keeps the input side closed
  `TCW_ASSERT_NEXT(a_full_after_reset, rst, full && empty)

  // a reported cursor always lies on the screen
  `TCW_ASSERT_ALWAYS(a_col_in_range, !empty, int'(cursor_col) < COLUMNS)
  `TCW_ASSERT_ALWAYS(a_row_in_range, !empty, int'(cursor_row) < ROWS)

  // a waiting result beat is not lost or changed
  `TCW_ASSERT_HOLD(a_result_held, !empty && !pop,
                   !empty && $stable(cell_value) && $stable(cursor_row) && $stable(cursor_col))

endmodule

bind text_console_char_writer tcw_port_check #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_port_check (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .cell_value (cell_value),
  .cursor_row (cursor_row),
  .cursor_col (cursor_col)
);

`default_nettype wire
